// File: rtl/hyperloglog_sketch_bank_defines.svh
// Assertion helpers; clk_i and rst_ni must exist in the using scope.
`ifndef HYPERLOGLOG_SKETCH_BANK_DEFINES_SVH
`define HYPERLOGLOG_SKETCH_BANK_DEFINES_SVH

`define HLL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hll same-cycle assertion failed");

`define HLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hll next-cycle assertion failed");

`endif

// File: rtl/hll_pkg.sv
`default_nettype none

package hll_pkg;

  localparam int unsigned RANK_W    = 6;
  localparam int unsigned FRAC_BITS = 47;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned ZCNT_W    = 17;

  localparam logic [ZCNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [63:0] MIX_C0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  sketch;
    logic [63:0] key;
  } hll_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  harmonic_sum;
    logic [ZCNT_W-1:0] zero_count;
  } hll_out_t;

  // byte-wise priority encode: count of leading zeros, 64 when w is zero
  function automatic logic [6:0] lead_zeros(input logic [63:0] w);
    logic [7:0] nz;
    logic [3:0] blz [8];
    logic [7:0] cur;
    logic [6:0] n;
    logic       found;
    for (int b = 0; b < 8; b++) begin
      cur    = w[63-8*b -: 8];
      nz[b]  = |cur;
      blz[b] = 4'd8;
      for (int k = 0; k < 8; k++) begin
        if (cur[k]) begin
          blz[b] = 4'(7 - k);
        end
      end
    end
    n     = 7'd64;
    found = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!found && nz[b]) begin
        n     = 7'(8 * b) + 7'(blz[b]);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hll_mix.sv
`default_nettype none

module hll_mix import hll_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_PREP = 2'd1;
  localparam logic [1:0] H_MUL  = 2'd2;
  localparam logic [1:0] H_FIN  = 2'd3;

  // partial products of the low 64 bits of a 64x64 product
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        pass_q, pass_d;
  logic [63:0] z_q, z_d;
  logic [63:0] mop_q, mop_d;

  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  assign mul_c = pass_q ? MIX_C2 : MIX_C1;
  assign mul_a = (step_q == STEP_HL) ? mop_q[63:32] : mop_q[31:0];
  assign mul_b = (step_q == STEP_LH) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    z_d     = z_q;
    mop_d   = mop_q;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          z_d     = key_i + MIX_C0;
          pass_d  = 1'b0;
          state_d = H_PREP;
        end
      end
      H_PREP: begin
        mop_d   = pass_q ? (z_q ^ (z_q >> 27)) : (z_q ^ (z_q >> 30));
        step_d  = STEP_LL;
        state_d = H_MUL;
      end
      H_MUL: begin
        if (step_q == STEP_LL) begin
          z_d = prod;
        end else begin
          z_d = {z_q[63:32] + prod[31:0], z_q[31:0]};
        end
        if (step_q == STEP_HL) begin
          pass_d  = 1'b1;
          state_d = pass_q ? H_FIN : H_PREP;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      H_FIN: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= STEP_LL;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    mop_q <= mop_d;
  end

  assign done_o = (state_q == H_FIN);
  assign hash_o = z_q ^ (z_q >> 31);

endmodule

`default_nettype wire

// File: rtl/hyperloglog_sketch_bank.sv
// Bank of NUM_SKETCHES HyperLogLog sketches of 2^INDEX_BITS six-bit registers, kept in one
// single-port-read, single-port-write RAM. One item is in work at a time. In an add,
// the splitmix64 hash runs its two 64-bit products on one shared 32x32 multiplier,
// three partial products each, then the register is read, compared and written back. A read
// walks the sketch one register per cycle through the RAM read port
// and returns the Q17.47 sum of 2^-register (terms below 2^-47 dropped) and the count
// of zero registers. Sketch numbers beyond the bank, and all adds, return zeros. After reset
// the RAM is cleared one entry per cycle, all NUM_SKETCHES * 2^INDEX_BITS entries, with in_stall_o
// high. The result register lets the next item be taken while a result waits.
`default_nettype none

`include "hyperloglog_sketch_bank_defines.svh"

module hyperloglog_sketch_bank import hll_pkg::*; #(
  parameter int INDEX_BITS   = 16,
  parameter int NUM_SKETCHES = 32
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  hll_in_t  in_data_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output hll_out_t out_data_o
);

  localparam int SLOTS  = 1 << INDEX_BITS;
  localparam int DEPTH  = NUM_SKETCHES * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = INDEX_BITS + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_RANK  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  function automatic logic [SUM_W-1:0] rank_term(input logic [RANK_W-1:0] r);
    if (r <= RANK_W'(FRAC_BITS)) begin
      return SUM_W'(1) << (RANK_W'(FRAC_BITS) - r);
    end
    return '0;
  endfunction

  logic [2:0]            state_q, state_d;
  logic [ADDR_W-1:0]     clr_q, clr_d;
  logic [ADDR_W-1:0]     base_q, base_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [63:0]           hash_q, hash_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [ADDR_W-1:0]     waddr_q, waddr_d;
  logic                  rdv_q, rdv_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  hll_out_t              out_data_q, out_data_d;

  logic [RANK_W-1:0]     rank_mem [DEPTH];
  logic [RANK_W-1:0]     mem_rd_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [RANK_W-1:0]     mem_wdata;

  logic                  accept;
  logic                  in_range;
  logic                  mix_done;
  logic [63:0]           mix_hash;
  logic [INDEX_BITS-1:0] pos;
  logic [63:0]           rest;
  logic [RANK_W-1:0]     rank_new;
  logic [SUM_W:0]        sum_ext;
  logic [ZCNT_W-1:0]     zero_sat;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_range = int'(in_data_i.sketch) < NUM_SKETCHES;

  hll_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && in_range && (in_data_i.cmd == CMD_ADD)),
    .key_i   (in_data_i.key),
    .done_o  (mix_done),
    .hash_o  (mix_hash)
  );

  assign pos      = hash_q[63 -: INDEX_BITS];
  assign rest     = (hash_q << INDEX_BITS) | (64'(1) << (INDEX_BITS - 1));
  assign rank_new = RANK_W'(lead_zeros(rest) + 7'd1);
  assign rd_addr  = (state_q == ST_WALK) ? base_q + ADDR_W'(idx_q) : base_q + ADDR_W'(pos);

  assign sum_ext  = {1'b0, sum_q} + {1'b0, rank_term(mem_rd_q)};
  assign zero_sat = (32'(cnt_q) > 32'(COUNT_MAX)) ? COUNT_MAX : ZCNT_W'(cnt_q);

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && (rank_q > mem_rd_q));
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : waddr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : rank_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    idx_d       = idx_q;
    hash_d      = hash_q;
    rank_d      = rank_q;
    waddr_d     = waddr_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    rdv_d       = (state_q == ST_WALK);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          sum_d  = '0;
          cnt_d  = '0;
          idx_d  = '0;
          base_d = ADDR_W'({in_data_i.sketch, {INDEX_BITS{1'b0}}});
          if (!in_range) begin
            state_d = ST_DONE;
          end else if (in_data_i.cmd == CMD_READ) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (mix_done) begin
          hash_d  = mix_hash;
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        rank_d  = rank_new;
        waddr_d = rd_addr;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_DONE;
      end
      ST_WALK: begin
        idx_d = idx_q + INDEX_BITS'(1);
        if (&idx_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d.harmonic_sum = sum_q;
          out_data_d.zero_count   = zero_sat;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
    endcase

    if (rdv_q) begin
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (mem_rd_q == '0) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    idx_q      <= idx_d;
    hash_q     <= hash_d;
    rank_q     <= rank_d;
    waddr_q    <= waddr_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rank_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= rank_mem[rd_addr];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HLL_ASSERT_NEXT(a_accept_then_busy, in_valid_i && !in_stall_o, in_stall_o)
  `HLL_ASSERT_SAME(a_rank_in_range, state_q == ST_UPD, rank_q != '0 && 32'(rank_q) <= 65 - INDEX_BITS)
  `HLL_ASSERT_SAME(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hll_pkg::*;

  localparam int IDX_BITS  = 16;
  localparam int SKETCHES  = 32;
  localparam int RAND_ITEMS = 1880;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [SUM_W-1:0]  FRESH_SUM   = 64'h8000_0000_0000_0000;
  localparam logic [ZCNT_W-1:0] FRESH_ZEROS = 17'h10000;

  typedef struct {
    hll_in_t  item;
    bit       typed;
    hll_out_t want;
  } probe_row_t;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  hll_in_t  in_data = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  hll_out_t out_data_o;

  bit                steady = 1'b0;
  int                faults = 0;
  int unsigned       cycle_count = 0;
  hll_out_t          awaited_replies[$];
  logic [5:0]        rank_mem[int unsigned];
  logic [SUM_W-1:0]  sum_by_sketch[SKETCHES];
  int                zeros_by_sketch[SKETCHES];

  hyperloglog_sketch_bank #(
    .INDEX_BITS  (IDX_BITS),
    .NUM_SKETCHES(SKETCHES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** hyperloglog_sketch_bank: FAILED **");
    $finish;
  end

  function automatic logic [63:0] splitmix(input logic [63:0] k);
    logic [63:0] z;
    z = k + MIX_C0;
    z = (z ^ (z >> 30)) * MIX_C1;
    z = (z ^ (z >> 27)) * MIX_C2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] unshift_xor(input logic [63:0] y, input int s);
    logic [63:0] x;
    x = y;
    repeat (64 / s + 1) x = y ^ (x >> s);
    return x;
  endfunction

  function automatic logic [63:0] odd_inverse(input logic [63:0] c);
    logic [63:0] x;
    x = c;
    repeat (6) x = x * (64'd2 - c * x);
    return x;
  endfunction

  // inverts splitmix, so a key can be made for any wanted hash
  function automatic logic [63:0] key_for_hash(input logic [63:0] h);
    logic [63:0] z;
    z = unshift_xor(h, 31) * odd_inverse(MIX_C2);
    z = unshift_xor(z, 27) * odd_inverse(MIX_C1);
    return unshift_xor(z, 30) - MIX_C0;
  endfunction

  // key landing in register idx with rank r (1..49)
  function automatic logic [63:0] key_with_rank(input logic [15:0] idx, input int r);
    logic [47:0] tail;
    tail = 48'({$urandom, $urandom});
    if (r >= 49) begin
      tail = '0;
    end else begin
      tail = (tail & ((48'd1 << (48 - r)) - 48'd1)) | (48'd1 << (48 - r));
    end
    return key_for_hash({idx, tail});
  endfunction

  function automatic logic [SUM_W-1:0] rank_weight(input int r);
    return (r <= FRAC_BITS) ? (64'd1 << (FRAC_BITS - r)) : '0;
  endfunction

  function automatic hll_out_t sketch_reply(input hll_in_t t);
    hll_out_t    o;
    logic [63:0] h;
    logic [63:0] rest;
    int          lz;
    int          rank;
    int          prior;
    int unsigned slot;
    o = '0;
    if (t.cmd == CMD_ADD) begin
      h    = splitmix(t.key);
      rest = (h << IDX_BITS) | (64'd1 << (IDX_BITS - 1));
      lz   = 0;
      while (lz < 64 && !rest[63-lz]) lz++;
      rank  = lz + 1;
      slot  = 32'({t.sketch, h[63 -: IDX_BITS]});
      prior = rank_mem.exists(slot) ? int'(rank_mem[slot]) : 0;
      if (rank > prior) begin
        sum_by_sketch[t.sketch] = sum_by_sketch[t.sketch] - rank_weight(prior)
                                  + rank_weight(rank);
        if (prior == 0) zeros_by_sketch[t.sketch]--;
        rank_mem[slot] = 6'(rank);
      end
    end else begin
      o.harmonic_sum = sum_by_sketch[t.sketch];
      o.zero_count   = ZCNT_W'(zeros_by_sketch[t.sketch]);
    end
    return o;
  endfunction

  function automatic probe_row_t probe(input logic cmd, input logic [4:0] sk,
                                      input logic [63:0] key, input bit typed,
                                      input hll_out_t want);
    probe_row_t p;
    p.item  = '{cmd: cmd, sketch: sk, key: key};
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  task automatic send_item(input hll_in_t item, input bit typed, input hll_out_t want);
    hll_out_t predicted;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = sketch_reply(item);
    awaited_replies.push_back(typed ? want : predicted);
  endtask

  always @(negedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 16);
  end

  always @(posedge clk_i) begin
    hll_out_t exp_o;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected transfer, got sum %h zeros %h", $time,
                 out_data_o.harmonic_sum, out_data_o.zero_count);
        faults++;
      end else begin
        exp_o = awaited_replies.pop_front();
        if (out_data_o.harmonic_sum !== exp_o.harmonic_sum) begin
          $display("%0t: harmonic_sum expected %h got %h", $time,
                   exp_o.harmonic_sum, out_data_o.harmonic_sum);
          faults++;
        end
        if (out_data_o.zero_count !== exp_o.zero_count) begin
          $display("%0t: zero_count expected %0d got %0d", $time,
                   exp_o.zero_count, out_data_o.zero_count);
          faults++;
        end
      end
    end
  end

  initial begin
    probe_row_t  rows[$];
    hll_out_t    nil_o;
    hll_out_t    fresh_o;
    hll_in_t     t;
    logic [4:0]  hot[3];
    int unsigned pick;

    nil_o   = '0;
    fresh_o = '{harmonic_sum: FRESH_SUM, zero_count: FRESH_ZEROS};
    foreach (sum_by_sketch[s]) begin
      sum_by_sketch[s]   = FRESH_SUM;
      zeros_by_sketch[s] = 1 << IDX_BITS;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    rows.push_back(probe(CMD_READ, 5'd0,  '0, 1'b1, fresh_o));
    rows.push_back(probe(CMD_READ, 5'd31, '1, 1'b1, fresh_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  '0, 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd31, '1, 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0000, 49), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'hFFFF, 48), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0001, 47), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0002, 1), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0002, 3), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0002, 2), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd0,  key_with_rank(16'h0000, 1), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd31, key_with_rank(16'hFFFF, 49), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd31, key_with_rank(16'hFFFF, 1), 1'b1, nil_o));
    rows.push_back(probe(CMD_ADD,  5'd5,  64'h8000_0000_0000_0000, 1'b1, nil_o));
    rows.push_back(probe(CMD_READ, 5'd0,  64'h5555_AAAA_5555_AAAA, 1'b0, nil_o));
    rows.push_back(probe(CMD_READ, 5'd31, '0, 1'b0, nil_o));

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    foreach (hot[i]) hot[i] = 5'($urandom_range(0, SKETCHES - 1));
    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady = (n >= 900 && n < 1200);
      pick   = $urandom_range(0, 299);
      t.key  = {$urandom, $urandom};
      if (pick == 0) begin
        t.cmd    = CMD_READ;
        t.sketch = ($urandom_range(0, 3) == 0) ? 5'($urandom) : hot[$urandom_range(0, 2)];
      end else if (pick < 120) begin
        t.cmd    = CMD_ADD;
        t.sketch = 5'($urandom);
      end else begin
        t.cmd    = CMD_ADD;
        t.sketch = hot[$urandom_range(0, 2)];
        t.key    = key_with_rank($urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                                      : 16'($urandom),
                                 $urandom_range(1, 49));
      end
      send_item(t, 1'b0, nil_o);
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (awaited_replies.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (faults == 0) begin
      $display("** hyperloglog_sketch_bank: PASSED **");
    end else begin
      $display("** hyperloglog_sketch_bank: FAILED **");
    end
    $finish;
  end

endmodule
